FILE: src/tmsw_pkg.sv
// ----------------------------------------------------------------------------
// tmsw_pkg: shared definitions for the text-mode screen writer
// Stream field layout, command codes, character codes and sequencer states.
// ----------------------------------------------------------------------------
`default_nettype none

package tmsw_pkg;

  // Command codes carried in the mode field
  typedef enum logic [1:0] {
    MODE_PUT   = 2'd0,
    MODE_CLEAR = 2'd1,
    MODE_SET   = 2'd2,
    MODE_READ  = 2'd3
  } mode_t;

  // Character codes
  localparam logic [7:0] CODE_NEWLINE = 8'd10;
  localparam logic [7:0] CODE_RETURN  = 8'd13;
  localparam logic [7:0] BLANK_CHAR   = 8'd32;
  localparam logic [7:0] PRINT_LOW    = 8'd31;
  localparam logic [7:0] PRINT_HIGH   = 8'd127;

  // Reset value of the clear attribute: white on black
  localparam logic [7:0] BLANK_ATTR_RESET = 8'd7;

  // Field widths fixed by the stream format
  localparam int MODE_W  = 2;
  localparam int CHAR_W  = 8;
  localparam int ATTR_W  = 8;
  localparam int COLF_W  = 7;
  localparam int ROWF_W  = 5;

  // Input tdata bit offsets, first field in the lowest bits
  localparam int IN_MODE_LSB = 0;
  localparam int IN_CHAR_LSB = IN_MODE_LSB + MODE_W;
  localparam int IN_ATTR_LSB = IN_CHAR_LSB + CHAR_W;
  localparam int IN_COL_LSB  = IN_ATTR_LSB + ATTR_W;
  localparam int IN_ROW_LSB  = IN_COL_LSB + COLF_W;
  localparam int IN_DATA_W   = 32;

  // Output tdata bit offsets
  localparam int OUT_COL_LSB    = 0;
  localparam int OUT_ROW_LSB    = OUT_COL_LSB + COLF_W;
  localparam int OUT_CHAR_LSB   = OUT_ROW_LSB + ROWF_W;
  localparam int OUT_ATTR_LSB   = OUT_CHAR_LSB + CHAR_W;
  localparam int OUT_SCROLL_LSB = OUT_ATTR_LSB + ATTR_W;
  localparam int OUT_USED_W     = OUT_SCROLL_LSB + 1;
  localparam int OUT_DATA_W     = 32;

  // Sequencer states, one-hot
  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_MOVE  = 5'b00010,
    ST_FLUSH = 5'b00100,
    ST_FILL  = 5'b01000,
    ST_DONE  = 5'b10000
  } state_t;

endpackage

`default_nettype wire

FILE: src/text_mode_screen_writer.sv
// ----------------------------------------------------------------------------
// text_mode_screen_writer: character cell screen store with cursor
// Stores a grid of character/attribute cells and executes put, clear,
// set cursor and read commands, scrolling by row copies when needed.
// ----------------------------------------------------------------------------
// Usage:
//   Commands enter on the s_tvalid/s_tready/s_tdata stream, one transaction
//   per command. Every command returns exactly one result transaction on the
//   m_tvalid/m_tready/m_tdata stream. The user must write the clear
//   attribute only while no command is in flight; the block does not check.
// Command flow:
//   Set cursor, read and a put that needs no scroll execute in the accept
//   cycle; the result register then loads in the done state once the
//   output is free. A scroll walks the cell memory through its single write
//   port, one copy per cell of the lower rows, then the blank last row.
//   Clear writes every cell once. A new command is accepted only after the
//   sequencer has returned to idle.
// Reset:
//   The cursor goes home and the clear attribute returns to white on black.
//   Cell contents are undefined until a clear or a put writes them.
// Stall:
//   A held result keeps the sequencer in its final state; no new command is
//   accepted until the result transaction completes or the output is free.
// ----------------------------------------------------------------------------
`default_nettype none

module text_mode_screen_writer #(
  parameter int SCREEN_COLUMNS = 80,
  parameter int SCREEN_ROWS    = 25
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // Command stream. tdata fields from bit 0: mode[1:0], char_code[7:0],
  // char_attr[7:0], column[6:0], row[4:0], two zero pad bits.
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [31:0] s_tdata,
  // Result stream. tdata fields from bit 0: cursor_column[6:0],
  // cursor_row[4:0], cell_char[7:0], cell_attr[7:0], scrolled, three pad bits.
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [31:0]      m_tdata,
  // Clear attribute register write
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [7:0]  cfg_data
);

  localparam int COL_W     = $clog2(SCREEN_COLUMNS);
  localparam int ROW_W     = $clog2(SCREEN_ROWS);
  localparam int ADDR_W    = ROW_W + COL_W;
  localparam int MEM_DEPTH = SCREEN_ROWS * (2 ** COL_W);
  localparam logic [COL_W-1:0] LAST_COL = COL_W'(SCREEN_COLUMNS - 1);
  localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(SCREEN_ROWS - 1);

  // Registers
  tmsw_pkg::state_t   state;
  logic [COL_W-1:0]   cursor_col;
  logic [ROW_W-1:0]   cursor_row;
  logic [7:0]         blank_attr;
  logic [7:0]         cur_attr;
  logic [COL_W-1:0]   scan_col;
  logic [ROW_W-1:0]   scan_row;
  logic [ADDR_W-1:0]  dst_addr;
  logic               move_pend;
  logic               res_scrolled;
  logic               res_read;

  // Cell memory: attribute in the high byte, character in the low byte
  logic [15:0]        mem [0:MEM_DEPTH-1];
  logic [15:0]        mem_rdata;
  logic               mem_we;
  logic               mem_re;
  logic [ADDR_W-1:0]  mem_waddr;
  logic [ADDR_W-1:0]  mem_raddr;
  logic [15:0]        mem_wdata;

  // Decoded command fields
  tmsw_pkg::mode_t         in_mode;
  logic [7:0]              in_char;
  logic [7:0]              in_attr;
  logic [6:0]              in_col;
  logic [4:0]              in_row;
  logic [COL_W-1:0]        sat_col;
  logic [ROW_W-1:0]        sat_row;
  logic                    accept;
  logic                    printable;
  logic                    scan_last;
  logic                    out_free;

  assign in_mode = tmsw_pkg::mode_t'(s_tdata[tmsw_pkg::IN_MODE_LSB +: tmsw_pkg::MODE_W]);
  assign in_char = s_tdata[tmsw_pkg::IN_CHAR_LSB +: tmsw_pkg::CHAR_W];
  assign in_attr = s_tdata[tmsw_pkg::IN_ATTR_LSB +: tmsw_pkg::ATTR_W];
  assign in_col  = s_tdata[tmsw_pkg::IN_COL_LSB +: tmsw_pkg::COLF_W];
  assign in_row  = s_tdata[tmsw_pkg::IN_ROW_LSB +: tmsw_pkg::ROWF_W];

  // Positions saturate to the screen
  assign sat_col = (32'(in_col) > SCREEN_COLUMNS - 1) ? LAST_COL : COL_W'(in_col);
  assign sat_row = (32'(in_row) > SCREEN_ROWS - 1) ? LAST_ROW : ROW_W'(in_row);

  assign printable = (in_char > tmsw_pkg::PRINT_LOW) && (in_char < tmsw_pkg::PRINT_HIGH);
  assign s_tready  = (state == tmsw_pkg::ST_IDLE) && !rst;
  assign cfg_ready = !rst;
  assign accept    = s_tvalid && s_tready;
  assign scan_last = (scan_row == LAST_ROW) && (scan_col == LAST_COL);
  assign out_free  = !m_tvalid || m_tready;

  // Memory port control
  always_comb begin
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_waddr = {cursor_row, cursor_col};
    mem_raddr = {sat_row, sat_col};
    mem_wdata = {in_attr, in_char};
    unique case (state)
      tmsw_pkg::ST_IDLE: begin
        mem_we = accept && (in_mode == tmsw_pkg::MODE_PUT) && printable;
        mem_re = accept && (in_mode == tmsw_pkg::MODE_READ);
      end
      tmsw_pkg::ST_MOVE: begin
        mem_re    = 1'b1;
        mem_raddr = {scan_row, scan_col};
        mem_we    = move_pend;
        mem_waddr = dst_addr;
        mem_wdata = mem_rdata;
      end
      tmsw_pkg::ST_FLUSH: begin
        mem_we    = 1'b1;
        mem_waddr = dst_addr;
        mem_wdata = mem_rdata;
      end
      tmsw_pkg::ST_FILL: begin
        mem_we    = 1'b1;
        mem_waddr = {scan_row, scan_col};
        mem_wdata = {cur_attr, tmsw_pkg::BLANK_CHAR};
      end
      tmsw_pkg::ST_DONE: begin
        mem_we = 1'b0;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  // Cell memory with registered read data
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_rdata <= mem[mem_raddr];
    end
  end

  // Clear attribute register
  always_ff @(posedge clk) begin
    if (rst) begin
      blank_attr <= tmsw_pkg::BLANK_ATTR_RESET;
    end else if (cfg_valid && cfg_ready) begin
      blank_attr <= cfg_data;
    end
  end

  // Sequencer, cursor and scan counters
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= tmsw_pkg::ST_IDLE;
      cursor_col   <= '0;
      cursor_row   <= '0;
      cur_attr     <= tmsw_pkg::BLANK_ATTR_RESET;
      scan_col     <= '0;
      scan_row     <= '0;
      move_pend    <= 1'b0;
      res_scrolled <= 1'b0;
      res_read     <= 1'b0;
    end else begin
      unique case (state)
        tmsw_pkg::ST_IDLE: begin
          if (accept) begin
            res_scrolled <= 1'b0;
            res_read     <= (in_mode == tmsw_pkg::MODE_READ);
            move_pend    <= 1'b0;
            scan_col     <= '0;
            scan_row     <= ROW_W'(1);
            state        <= tmsw_pkg::ST_DONE;
            unique case (in_mode)
              tmsw_pkg::MODE_PUT: begin
                if (in_char == tmsw_pkg::CODE_RETURN) begin
                  cursor_col <= '0;
                end else if ((in_char == tmsw_pkg::CODE_NEWLINE) ||
                             (printable && (cursor_col == LAST_COL))) begin
                  // Next line, scrolling from the bottom row
                  cursor_col <= '0;
                  if (cursor_row != LAST_ROW) begin
                    cursor_row <= cursor_row + ROW_W'(1);
                  end else begin
                    res_scrolled <= 1'b1;
                    state        <= tmsw_pkg::ST_MOVE;
                  end
                end else if (printable) begin
                  cursor_col <= cursor_col + COL_W'(1);
                end
                if (printable) begin
                  cur_attr <= in_attr;
                end
              end
              tmsw_pkg::MODE_CLEAR: begin
                cur_attr   <= blank_attr;
                cursor_col <= '0;
                cursor_row <= '0;
                scan_row   <= '0;
                state      <= tmsw_pkg::ST_FILL;
              end
              tmsw_pkg::MODE_SET: begin
                cursor_col <= sat_col;
                cursor_row <= sat_row;
              end
              tmsw_pkg::MODE_READ: begin
                cursor_col <= cursor_col;
              end
              default: begin
                cursor_col <= cursor_col;
              end
            endcase
          end
        end
        tmsw_pkg::ST_MOVE: begin
          // Read one cell, write the previous one a row higher
          move_pend <= 1'b1;
          dst_addr  <= {ROW_W'(scan_row - ROW_W'(1)), scan_col};
          if (scan_last) begin
            state <= tmsw_pkg::ST_FLUSH;
          end else if (scan_col == LAST_COL) begin
            scan_col <= '0;
            scan_row <= scan_row + ROW_W'(1);
          end else begin
            scan_col <= scan_col + COL_W'(1);
          end
        end
        tmsw_pkg::ST_FLUSH: begin
          move_pend <= 1'b0;
          scan_col  <= '0;
          scan_row  <= LAST_ROW;
          state     <= tmsw_pkg::ST_FILL;
        end
        tmsw_pkg::ST_FILL: begin
          if (scan_last) begin
            state <= tmsw_pkg::ST_DONE;
          end else if (scan_col == LAST_COL) begin
            scan_col <= '0;
            scan_row <= scan_row + ROW_W'(1);
          end else begin
            scan_col <= scan_col + COL_W'(1);
          end
        end
        tmsw_pkg::ST_DONE: begin
          if (out_free) begin
            state <= tmsw_pkg::ST_IDLE;
          end
        end
        default: begin
          state <= tmsw_pkg::ST_IDLE;
        end
      endcase
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if ((state == tmsw_pkg::ST_DONE) && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  // Result fields packed from bit 0, zero padded to the bus width
  always_ff @(posedge clk) begin
    if ((state == tmsw_pkg::ST_DONE) && out_free) begin
      m_tdata <= tmsw_pkg::OUT_DATA_W'({res_scrolled,
                                        (res_read ? mem_rdata[15:8] : 8'd0),
                                        (res_read ? mem_rdata[7:0] : 8'd0),
                                        tmsw_pkg::ROWF_W'(cursor_row),
                                        tmsw_pkg::COLF_W'(cursor_col)});
    end
  end

  // Assertions
  a_cursor_range: assert property (@(posedge clk) disable iff (rst)
    (cursor_col <= LAST_COL) && (cursor_row <= LAST_ROW))
    else $error("cursor left the screen");

  a_clear_fills: assert property (@(posedge clk) disable iff (rst)
    (accept && (in_mode == tmsw_pkg::MODE_CLEAR)) |=> (state == tmsw_pkg::ST_FILL))
    else $error("clear did not start the fill sweep");

  a_scroll_bottom: assert property (@(posedge clk) disable iff (rst)
    (state == tmsw_pkg::ST_MOVE) |-> ((cursor_row == LAST_ROW) && res_scrolled))
    else $error("scroll sweep without cursor on the last row");

  a_result_issue: assert property (@(posedge clk) disable iff (rst)
    ((state == tmsw_pkg::ST_DONE) && out_free) |=> (m_tvalid && s_tready))
    else $error("finished command did not post a result");

endmodule

`default_nettype wire
